>>> sv/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types, constants and helpers for the pixel alpha compositor.
// ----------------------------------------------------------------------------
package pac_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SOFT_MASK_ON  = 3'd0,
    CFG_SHAPE_ON      = 3'd1,
    CFG_BACKDROP_ON   = 3'd2,
    CFG_NON_ISOLATED  = 3'd3,
    CFG_KNOCKOUT_ON   = 3'd4,
    CFG_KNOCKOUT_LVL  = 3'd5,
    CFG_OPAQUE_MODE   = 3'd6,
    CFG_CHANNELS_RGB  = 3'd7
  } cfg_idx_t;

  localparam logic [7:0]  ALPHA_FULL = 8'hff;
  // ceil(2^32 / 255), exact for dividends below 2^24
  localparam logic [24:0] RECIP_255  = 25'h1010102;
  localparam int          NUM_LANES  = 3;

  // per-channel operands handed to a lane
  typedef struct packed {
    logic [7:0]         s;
    logic [7:0]         d;
    logic signed [16:0] t;
    logic               corr;
    logic [7:0]         as;
    logic [7:0]         ai;
  } lane_in_t;

  // rounded divide by 255 of a 16-bit product
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'b0, x[15:8]} + 17'd128;
    return sum[15:8];
  endfunction

endpackage

>>> sv/pixel_alpha_compositor.sv
// ----------------------------------------------------------------------------
// pixel_alpha_compositor
// Source-over compositing of one gray or RGB pixel per beat, three lanes.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle, set by the fully pipelined dividers
// the whole pipeline holds while a result waits on out_tready
// reset: synchronous, clears valid bits and loads register defaults
module pixel_alpha_compositor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // src_c0, src_c1, src_c2, dst_c0, dst_c1, dst_c2, dst_alpha, src_alpha,
  // shape_val, mask_val, backdrop_alpha
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // res_c0, res_c1, res_c2, res_alpha
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [7:0]  cfg_wdata
);

  localparam int NS = 22;

  typedef struct packed {
    logic [2:0][7:0] s;
    logic [2:0][7:0] d;
    logic [7:0]      ad;
    logic [7:0]      ad_org;
    logic [7:0]      as;
    logic [7:0]      shp;
    logic [7:0]      msk;
    logic [7:0]      bd;
    logic [15:0]     prod;
    logic [7:0]      ar;
    logic [7:0]      ai;
  } pix_t;

  logic soft_mask_on_r, shape_on_r, backdrop_on_r, non_isolated_r;
  logic knockout_on_r, opaque_mode_r, rgb_r;
  logic [7:0] knockout_level_r;

  pix_t p_r [NS+1];
  pix_t p_nxt [NS+1];
  logic vld_r [NS+1];
  logic out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic [31:0] out_tdata_nxt;
  logic en;
  logic [15:0] tq;
  logic [7:0] res [pac_pkg::NUM_LANES];
  pac_pkg::lane_in_t li [pac_pkg::NUM_LANES];
  logic [9:0] ar_sum, ai_sum;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_mask_on_r   <= 1'b0;
      shape_on_r       <= 1'b0;
      backdrop_on_r    <= 1'b0;
      non_isolated_r   <= 1'b0;
      knockout_on_r    <= 1'b0;
      knockout_level_r <= 8'hff;
      opaque_mode_r    <= 1'b0;
      rgb_r            <= 1'b1;
    end else if (cfg_we) begin
      case (pac_pkg::cfg_idx_t'(cfg_idx))
        pac_pkg::CFG_SOFT_MASK_ON: soft_mask_on_r   <= cfg_wdata[0];
        pac_pkg::CFG_SHAPE_ON:     shape_on_r       <= cfg_wdata[0];
        pac_pkg::CFG_BACKDROP_ON:  backdrop_on_r    <= cfg_wdata[0];
        pac_pkg::CFG_NON_ISOLATED: non_isolated_r   <= cfg_wdata[0];
        pac_pkg::CFG_KNOCKOUT_ON:  knockout_on_r    <= cfg_wdata[0];
        pac_pkg::CFG_KNOCKOUT_LVL: knockout_level_r <= cfg_wdata;
        pac_pkg::CFG_OPAQUE_MODE:  opaque_mode_r    <= cfg_wdata[0];
        pac_pkg::CFG_CHANNELS_RGB: rgb_r            <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // alpha path along the pixel pipeline
  always_comb begin
    p_nxt[0]        = p_r[0];
    p_nxt[0].s[0]   = in_tdata[7:0];
    p_nxt[0].s[1]   = in_tdata[15:8];
    p_nxt[0].s[2]   = in_tdata[23:16];
    p_nxt[0].d[0]   = in_tdata[31:24];
    p_nxt[0].d[1]   = in_tdata[39:32];
    p_nxt[0].d[2]   = in_tdata[47:40];
    p_nxt[0].ad     = in_tdata[55:48];
    p_nxt[0].ad_org = in_tdata[55:48];
    p_nxt[0].as     = in_tdata[63:56];
    p_nxt[0].shp    = in_tdata[71:64];
    p_nxt[0].msk    = in_tdata[79:72];
    p_nxt[0].bd     = in_tdata[87:80];
    for (int i = 1; i <= NS; i++) p_nxt[i] = p_r[i-1];
    // soft mask and knockout
    if (soft_mask_on_r) p_nxt[1].as = pac_pkg::div255(16'(p_r[0].as) * 16'(p_r[0].msk));
    if (non_isolated_r && p_r[0].shp != 8'd0 && knockout_on_r &&
        p_r[0].shp >= knockout_level_r) p_nxt[1].ad = 8'd0;
    // shape
    if (shape_on_r) p_nxt[2].as = pac_pkg::div255(16'(p_r[1].as) * 16'(p_r[1].shp));
    // result alpha
    p_nxt[3].prod = 16'(p_r[2].as) * 16'(p_r[2].ad);
    ar_sum = 10'(p_r[3].as) + 10'(p_r[3].ad) - 10'(pac_pkg::div255(p_r[3].prod));
    p_nxt[4].ar = ar_sum[7:0];
    // backdrop combined alpha
    p_nxt[5].prod = 16'(p_r[4].ar) * 16'(p_r[4].bd);
    ai_sum = 10'(p_r[5].ar) + 10'(p_r[5].bd) - 10'(pac_pkg::div255(p_r[5].prod));
    p_nxt[6].ai = backdrop_on_r ? ai_sum[7:0] : p_r[5].ar;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i <= NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= NS; i++) p_r[i] <= p_nxt[i];
    end
  end

  // quotient of backdrop correction, lines up with stage 8
  pac_div #(.NW(16)) u_tdiv (
    .clk (clk),
    .en  (en),
    .num ({p_r[0].ad, 8'd0} - 16'(p_r[0].ad)),
    .den (p_r[0].shp),
    .quo (tq)
  );

  // color lanes
  for (genvar k = 0; k < pac_pkg::NUM_LANES; k++) begin : g_lane
    always_comb begin
      li[k].s    = p_r[8].s[k];
      li[k].d    = p_r[8].d[k];
      li[k].t    = $signed({1'b0, tq}) - $signed({9'b0, p_r[8].ad_org});
      li[k].corr = non_isolated_r && (p_r[8].shp != 8'd0);
      li[k].as   = p_r[8].as;
      li[k].ai   = p_r[8].ai;
    end
    pac_lane u_lane (
      .clk (clk),
      .en  (en),
      .li  (li[k]),
      .res (res[k])
    );
  end

  // merge lanes into the result beat
  always_comb begin
    if (opaque_mode_r) begin
      out_tdata_nxt = {pac_pkg::ALPHA_FULL, rgb_r ? p_r[NS].s[2] : 8'd0,
                       rgb_r ? p_r[NS].s[1] : 8'd0, p_r[NS].s[0]};
    end else begin
      out_tdata_nxt = {p_r[NS].ar, rgb_r ? res[2] : 8'd0,
                       rgb_r ? res[1] : 8'd0, res[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (en) out_tvalid_r <= vld_r[NS];
  end

  always_ff @(posedge clk) begin
    if (en) out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && opaque_mode_r |-> out_tdata_r[31:24] == pac_pkg::ALPHA_FULL)
    else $error("opaque beat without full alpha");
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !rgb_r |-> out_tdata_r[23:8] == 16'd0)
    else $error("gray beat with nonzero upper channels");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS] && en |=> out_tvalid_r)
    else $error("last stage beat lost");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready |-> !in_tready ##1 (out_tvalid_r && $stable(out_tdata_r)))
    else $error("pipeline moved under stall");

endmodule

>>> sv/pac_div.sv
// ----------------------------------------------------------------------------
// pac_div
// Pipelined unsigned restoring divider by an 8-bit divisor, two bits a stage.
// ----------------------------------------------------------------------------
module pac_div #(
  parameter int NW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [7:0]    den,
  output logic [NW-1:0] quo
);

  localparam int STG = (NW + 1) / 2;
  localparam int NP  = 2 * STG;

  logic [7:0]    rem_r [STG];
  logic [NP-1:0] acc_r [STG];
  logic [7:0]    den_r [STG];
  logic [7:0]    rem_nxt [STG];
  logic [NP-1:0] acc_nxt [STG];
  logic [7:0]    den_nxt [STG];

  // two restoring steps
  function automatic logic [8+NP-1:0] step2(input logic [7:0] rem,
                                            input logic [NP-1:0] acc,
                                            input logic [7:0] dv);
    logic [8:0]    r;
    logic [7:0]    rr;
    logic [NP-1:0] a;
    rr = rem;
    a  = acc;
    for (int k = 0; k < 2; k++) begin
      r = {rr, a[NP-1]};
      a = {a[NP-2:0], 1'b0};
      if (r >= {1'b0, dv}) begin
        r    = r - {1'b0, dv};
        a[0] = 1'b1;
      end
      rr = r[7:0];
    end
    return {rr, a};
  endfunction

  // stage logic
  always_comb begin
    for (int s = 0; s < STG; s++) begin
      if (s == 0) begin
        {rem_nxt[s], acc_nxt[s]} = step2(8'd0, NP'(num), den);
        den_nxt[s] = den;
      end else begin
        {rem_nxt[s], acc_nxt[s]} = step2(rem_r[s-1], acc_r[s-1], den_r[s-1]);
        den_nxt[s] = den_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STG; s++) begin
        rem_r[s] <= rem_nxt[s];
        acc_r[s] <= acc_nxt[s];
        den_r[s] <= den_nxt[s];
      end
    end
  end

  assign quo = acc_r[STG-1][NW-1:0];

endmodule

>>> sv/pac_lane.sv
// ----------------------------------------------------------------------------
// pac_lane
// One color channel: non-isolated correction and weighted blend, 14 stages.
// ----------------------------------------------------------------------------
module pac_lane (
  input  logic              clk,
  input  logic              en,
  input  pac_pkg::lane_in_t li,
  output logic [7:0]        res
);

  localparam int DLAT = 9;

  // stage 1
  pac_pkg::lane_in_t  l1_r;
  logic signed [25:0] prod1_r;
  // stage 2
  pac_pkg::lane_in_t  l2_r;
  logic [15:0]        qm_r;
  logic               qneg_r;
  // stage 3
  pac_pkg::lane_in_t  l3_r;
  logic [7:0]         cs_r;
  // stage 4
  logic signed [17:0] m1_r;
  logic [15:0]        m2_r;
  logic               zero4_r;
  logic [7:0]         ai4_r;
  // divider side band
  logic               neg_r  [DLAT];
  logic               zero_r [DLAT];
  logic [7:0]         res_r;

  logic signed [8:0]  diff;
  logic [24:0]        mag1;
  logic [48:0]        rprod;
  logic signed [17:0] csum;
  logic signed [8:0]  wdiff;
  logic signed [18:0] num;
  logic [17:0]        nmag;
  logic [17:0]        quo;
  logic [7:0]         res_nxt;

  always_comb begin
    diff  = $signed({1'b0, li.s}) - $signed({1'b0, li.d});
    mag1  = prod1_r[25] ? 25'(-prod1_r) : prod1_r[24:0];
    rprod = 49'(mag1[23:0]) * 49'(pac_pkg::RECIP_255);
    csum  = $signed({10'b0, l2_r.s}) +
            (qneg_r ? -$signed({2'b0, qm_r}) : $signed({2'b0, qm_r}));
    wdiff = $signed({1'b0, l3_r.ai}) - $signed({1'b0, l3_r.as});
    num   = 19'(m1_r) + $signed({3'b0, m2_r});
    nmag  = num[18] ? 18'(-num) : num[17:0];
    if (zero_r[DLAT-1] || neg_r[DLAT-1]) res_nxt = 8'd0;
    else if (quo > 18'd255)             res_nxt = 8'hff;
    else                                res_nxt = quo[7:0];
  end

  // magnitude divide of the weighted sum by the combined alpha
  pac_div #(.NW(18)) u_div (
    .clk (clk),
    .en  (en),
    .num (nmag),
    .den (ai4_r),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      // correction product
      l1_r    <= li;
      prod1_r <= 26'(diff) * 26'(li.t);
      // divide by 255 toward zero
      l2_r    <= l1_r;
      qm_r    <= rprod[47:32];
      qneg_r  <= prod1_r[25];
      // clamped corrected source
      l3_r <= l2_r;
      if (!l2_r.corr)          cs_r <= l2_r.s;
      else if (csum < 0)       cs_r <= 8'd0;
      else if (csum > 18'sd255) cs_r <= 8'hff;
      else                     cs_r <= csum[7:0];
      // blend products
      m1_r    <= 18'(wdiff) * $signed({10'b0, l3_r.d});
      m2_r    <= 16'(l3_r.as) * 16'(cs_r);
      zero4_r <= (l3_r.ai == 8'd0);
      ai4_r   <= l3_r.ai;
      // side band follows the divider
      neg_r[0]  <= num[18];
      zero_r[0] <= zero4_r;
      for (int i = 1; i < DLAT; i++) begin
        neg_r[i]  <= neg_r[i-1];
        zero_r[i] <= zero_r[i-1];
      end
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
